[hw/rtl/mah_pkg.sv]
package mah_pkg;

  localparam int NUM_BANDS     = 7;
  localparam int MIN_PER_SLOT  = 5;
  localparam int RECENT_SPLIT  = 15;
  localparam int SHIFT_SEC     = 300;
  localparam int OUT_DEPTH     = 3;

  localparam int BAND_START_MIN [NUM_BANDS] = '{0, 10, 30, 60, 180, 360, 720};
  localparam int BAND_END_MIN   [NUM_BANDS] = '{10, 30, 60, 180, 360, 720, 1440};

  // item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COMMIT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] uptime;
  } in_item_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0] activity_bits;
    logic                 recent_moved;
    logic                 sample_moved;
  } result_t;

endpackage

[hw/rtl/mah_ifs.sv]
interface mah_in_if;
  logic               valid;
  logic               ready;
  mah_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mah_out_if;
  logic             valid;
  logic             ready;
  mah_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mah_axis_lane.sv]
module mah_axis_lane (
  input  logic signed [15:0] cur,
  input  logic signed [15:0] prev,
  input  logic        [15:0] threshold,
  output logic               moved
);

  logic signed [16:0] diff;
  logic        [16:0] mag;

  always_comb begin
    diff  = 17'(cur) - 17'(prev);
    mag   = diff[16] ? 17'(-diff) : 17'(diff);
    moved = mag > {1'b0, threshold};
  end

endmodule

[hw/rtl/mah_band_lane.sv]
module mah_band_lane #(
  parameter int LONG_SLOTS = 288,
  parameter int START      = 0,
  parameter int STOP       = 2
) (
  input  logic [LONG_SLOTS-1:0] hist,
  output logic                  hit
);

  assign hit = |hist[STOP-1:START];

endmodule

[hw/rtl/mah_out_fifo.sv]
module mah_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mah_pkg::result_t push_data,
  input  logic             pending,
  output logic             room,
  mah_out_if.source        out_ch
);

  localparam int DEPTH = mah_pkg::OUT_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  mah_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = count != '0;
  assign out_ch.data  = mem[rd_ptr];
  // reserve a slot for the transfer still in the update stage
  assign room = ({1'b0, count} + (CW+1)'(pending)) < (CW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/motion_activity_history_top.sv]
// Motion activity history. While input ready is high it takes one item per
// clock: an accelerometer sample (mode 0) or an end-of-reading commit
// (mode 1), and returns one result per item carrying the seven-band
// activity summary of the long history, the newest recent-history slot, and
// whether this sample moved past the threshold. Sustained rate is one item
// per cycle while result_out accepts results. State updates at the input
// transfer edge; during the following cycle the band lanes reduce the
// updated long history and the result is written into the output queue at
// the next edge. A three-entry output queue keeps input transfers flowing
// while results wait; input ready drops once the queue plus the item in the
// update stage would fill it. The threshold register is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, which
// the block itself does not enforce. All history state clears on reset.
module motion_activity_history_top #(
  parameter int RECENT_SLOTS = 30,
  parameter int LONG_SLOTS   = 288
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mah_in_if.sink      sample_in,
  mah_out_if.source   result_out
);

  localparam int NB = mah_pkg::NUM_BANDS;

  // configuration
  logic [15:0] move_threshold;

  // per-item state
  logic signed [15:0]     prev_x;
  logic signed [15:0]     prev_y;
  logic signed [15:0]     prev_z;
  logic                   prev_valid;
  logic [1:0]             move_count;
  logic [RECENT_SLOTS-1:0] recent_history;
  logic [LONG_SLOTS-1:0]   long_history;
  logic [31:0]            last_shift_sec;

  // update stage holding register
  logic s1_valid;
  logic s1_moved;

  logic                    accept;
  logic                    room;
  logic [2:0]              axis_hit;
  logic                    sample_moved;
  logic [RECENT_SLOTS-1:0] recent_next;
  logic [LONG_SLOTS-1:0]   long_next;
  logic                    shift_due;
  logic                    half_new;
  logic                    half_old;
  logic [NB-1:0]           band_hit;
  mah_pkg::result_t        result;

  assign sample_in.ready = room;
  assign accept          = sample_in.valid && sample_in.ready;

  // axis lanes: compare each axis with the stored sample
  mah_axis_lane u_lane_x (
    .cur(sample_in.data.accel_x), .prev(prev_x), .threshold(move_threshold),
    .moved(axis_hit[0])
  );
  mah_axis_lane u_lane_y (
    .cur(sample_in.data.accel_y), .prev(prev_y), .threshold(move_threshold),
    .moved(axis_hit[1])
  );
  mah_axis_lane u_lane_z (
    .cur(sample_in.data.accel_z), .prev(prev_z), .threshold(move_threshold),
    .moved(axis_hit[2])
  );

  // merge lanes; no comparison on the very first sample
  assign sample_moved = (sample_in.data.mode == mah_pkg::MODE_SAMPLE) &&
                        prev_valid && (|axis_hit);

  // commit: push into recent history, maybe age long history, then
  // overwrite the two newest long slots from the halves of recent history
  always_comb begin
    recent_next = {recent_history[RECENT_SLOTS-2:0], move_count > 2'd1};
    half_new    = |recent_next[mah_pkg::RECENT_SPLIT-1:0];
    half_old    = |recent_next[RECENT_SLOTS-1:mah_pkg::RECENT_SPLIT];
    shift_due   = {1'b0, sample_in.data.uptime} >
                  ({1'b0, last_shift_sec} + 33'(mah_pkg::SHIFT_SEC));
    long_next   = long_history;
    if (shift_due) begin
      long_next[LONG_SLOTS-1:2] = long_history[LONG_SLOTS-2:1];
    end
    long_next[1] = half_old;
    long_next[0] = half_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_z         <= '0;
      prev_valid     <= 1'b0;
      move_count     <= '0;
      recent_history <= '0;
      long_history   <= '0;
      last_shift_sec <= '0;
      s1_valid       <= 1'b0;
      s1_moved       <= 1'b0;
    end else begin
      if (cfg_we) begin
        move_threshold <= cfg_wdata;
      end
      s1_valid <= accept;
      if (accept) begin
        s1_moved <= sample_moved;
        if (sample_in.data.mode == mah_pkg::MODE_SAMPLE) begin
          prev_x     <= sample_in.data.accel_x;
          prev_y     <= sample_in.data.accel_y;
          prev_z     <= sample_in.data.accel_z;
          prev_valid <= 1'b1;
          // saturate at three
          if (sample_moved && move_count != 2'd3) begin
            move_count <= move_count + 2'd1;
          end
        end else begin
          recent_history <= recent_next;
          long_history   <= long_next;
          move_count     <= '0;
          if (shift_due) begin
            last_shift_sec <= sample_in.data.uptime;
          end
        end
      end
    end
  end

  // band lanes: each reduces its span of the long history, already
  // updated by the item now in the update stage; band ends clamp to the
  // history size and an out-of-range start falls back to slot 0
  for (genvar k = 0; k < NB; k++) begin : g_band
    localparam int S_RAW = mah_pkg::BAND_START_MIN[k] / mah_pkg::MIN_PER_SLOT;
    localparam int E_RAW = (mah_pkg::BAND_END_MIN[k] + mah_pkg::MIN_PER_SLOT - 1) /
                           mah_pkg::MIN_PER_SLOT;
    localparam int S     = (S_RAW >= LONG_SLOTS) ? 0 : S_RAW;
    localparam int E     = (E_RAW > LONG_SLOTS) ? LONG_SLOTS : E_RAW;

    mah_band_lane #(
      .LONG_SLOTS(LONG_SLOTS),
      .START     (S),
      .STOP      (E)
    ) u_band (
      .hist(long_history),
      .hit (band_hit[k])
    );
  end

  // merge band lanes into the result
  always_comb begin
    result.activity_bits = band_hit;
    result.recent_moved  = recent_history[0];
    result.sample_moved  = s1_moved;
  end

  mah_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(result),
    .pending  (s1_valid),
    .room     (room),
    .out_ch   (result_out)
  );

endmodule
